// ----- rtl/rational_accumulator_reduce_top_macros.svh -----
// Assertion macros shared by the rational accumulator RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef RATIONAL_ACCUMULATOR_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ACCUMULATOR_REDUCE_TOP_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define RAR_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define RAR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/rar_pkg.sv -----
// Shared constants, codes and control/status types for the rational accumulator.
// No dependencies; imported by rar_ctrl, rar_datapath and the top level.
`default_nettype none

package rar_pkg;

   localparam int STATE_BITS   = 32;
   localparam int OPERAND_BITS = 16;
   localparam int PROD_BITS    = STATE_BITS + OPERAND_BITS;
   localparam int CNT_BITS     = $clog2(STATE_BITS);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(STATE_BITS - 1);

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD = 2'd0;
   localparam op_type OP_ADD  = 2'd1;
   localparam op_type OP_MUL  = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ZERO_DEN = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   // Multiplier operand selection
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_DEN   = 2'd0;  // held_den * operand_den
   localparam mul_sel_type MUL_NUM   = 2'd1;  // held_num * operand_num or operand_den
   localparam mul_sel_type MUL_CROSS = 2'd2;  // operand_num * held_den

   typedef struct packed {
      logic        accept;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        form;
      logic        gcd_step;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   reduce_req;
      logic   gcd_equal;
      logic   div_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/rational_accumulator_reduce_top.sv -----
// Rational accumulator with gcd reduction: top level.
// Instantiates rar_ctrl and rar_datapath; depends on rar_pkg.
//
// Usage:
//   Input channel req_*: operation (load, add, multiply) and a 16-bit signed
//   operand fraction. An item is taken on a clock edge with req_valid high and
//   req_stall low. Result channel rsp_*: the stored fraction after the item and
//   a status (ok, add with a zero denominator, overflow). Every item yields
//   exactly one result. One item is in flight at a time.
//   After accept, the sequencer forms the denominator product, then for an add
//   or multiply the numerator product, for an add also the cross product; it
//   then forms the candidate fraction and, once the result register is free, loads it.
//   When an add or multiply result has positive numerator and denominator, the
//   binary gcd loop first runs one step per cycle and the bit-serial divider
//   then produces one quotient bit per cycle before the result is loaded.
//   Reset (synchronous, active high) sets the fraction to 0/1 and empties the
//   result register. While the receiver holds rsp_stall, the result stays put;
//   one new item can still be accepted and computed, then the block waits with
//   req_stall high until the waiting result is taken.
`default_nettype none

module rational_accumulator_reduce_top
   import rar_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire op_type                         req_operation,
   input  wire logic signed [OPERAND_BITS-1:0] req_operand_numerator,
   input  wire logic signed [OPERAND_BITS-1:0] req_operand_denominator,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [STATE_BITS-1:0]        rsp_result_numerator,
   output logic signed [STATE_BITS-1:0]        rsp_result_denominator,
   output status_type                          rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: handshakes and one command set per cycle
   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic, held fraction and result register
   rar_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_operation           (req_operation),
      .req_operand_numerator   (req_operand_numerator),
      .req_operand_denominator (req_operand_denominator),
      .rsp_result_numerator    (rsp_result_numerator),
      .rsp_result_denominator  (rsp_result_denominator),
      .rsp_status              (rsp_status)
   );

endmodule

`default_nettype wire

// ----- rtl/rar_ctrl.sv -----
// Sequencer for the rational accumulator: handshakes and step commands.
// Depends on rar_pkg; drives rar_datapath through cmd_type.
`default_nettype none

module rar_ctrl
   import rar_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MULD  = 3'd1;
   localparam logic [2:0] S_MULN  = 3'd2;
   localparam logic [2:0] S_MULX  = 3'd3;
   localparam logic [2:0] S_FORM  = 3'd4;
   localparam logic [2:0] S_GCD   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_DEN;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MULD;
            end
         end
         S_MULD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DEN;
            state_in    = (stat.op == OP_ADD || stat.op == OP_MUL) ? S_MULN : S_FORM;
         end
         S_MULN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NUM;
            state_in    = (stat.op == OP_ADD) ? S_MULX : S_FORM;
         end
         S_MULX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CROSS;
            state_in    = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = stat.reduce_req ? S_GCD : S_OUT;
         end
         S_GCD: begin
            cmd.gcd_step = 1'b1;
            if (stat.gcd_equal) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rar_datapath.sv -----
// Datapath for the rational accumulator: held fraction, shared multiplier,
// binary GCD unit, bit-serial dividers and result register. Depends on rar_pkg.
`default_nettype none

`include "rational_accumulator_reduce_top_macros.svh"

module rar_datapath
   import rar_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cmd_type                        cmd,
   output stat_type                            stat,
   input  wire op_type                         req_operation,
   input  wire logic signed [OPERAND_BITS-1:0] req_operand_numerator,
   input  wire logic signed [OPERAND_BITS-1:0] req_operand_denominator,
   output logic signed [STATE_BITS-1:0]        rsp_result_numerator,
   output logic signed [STATE_BITS-1:0]        rsp_result_denominator,
   output status_type                          rsp_status
);

   // held fraction
   logic signed [STATE_BITS-1:0]   hn_ff, hn_in, hd_ff, hd_in;
   // captured item
   op_type                         op_ff;
   logic signed [OPERAND_BITS-1:0] on_ff, od_ff;
   // products
   logic signed [STATE_BITS-1:0]   pd_ff, pn_ff, px_ff;
   logic                           ovf_ff, ovf_in;
   // candidate fraction
   logic signed [STATE_BITS-1:0]   cand_n_ff, cand_n_in, cand_d_ff, cand_d_in;
   status_type                     status_ff, status_in;
   logic                           commit_ff, commit_in;
   logic                           reduce_in;
   // gcd
   logic [STATE_BITS-1:0]          ga_ff, ga_in, gb_ff, gb_in;
   logic [CNT_BITS-1:0]            gk_ff, gk_in;
   // divide
   logic [STATE_BITS-1:0]          g_ff, g_in;
   logic [STATE_BITS-1:0]          qn_ff, qn_in, qd_ff, qd_in;
   logic [STATE_BITS-1:0]          rn_ff, rn_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   // result register
   logic signed [STATE_BITS-1:0]   out_n_ff, out_n_in, out_d_ff, out_d_in;
   status_type                     out_s_ff, out_s_in;

   logic signed [STATE_BITS-1:0]   mul_a;
   logic signed [OPERAND_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]    prod;
   logic                           prod_ovf;
   logic signed [STATE_BITS:0]     sum;
   logic                           sum_ovf;
   logic signed [STATE_BITS-1:0]   on_ext, od_ext;
   logic                           gcd_eq;
   logic [STATE_BITS-1:0]          rn_sh, rd_sh;

   assign on_ext = {{(STATE_BITS-OPERAND_BITS){on_ff[OPERAND_BITS-1]}}, on_ff};
   assign od_ext = {{(STATE_BITS-OPERAND_BITS){od_ff[OPERAND_BITS-1]}}, od_ff};

   // shared signed multiplier, one product per cycle
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_DEN: begin
            mul_a = hd_ff;
            mul_b = od_ff;
         end
         MUL_NUM: begin
            mul_a = hn_ff;
            mul_b = (op_ff == OP_ADD) ? od_ff : on_ff;
         end
         MUL_CROSS: begin
            mul_a = hd_ff;
            mul_b = on_ff;
         end
         default: begin
            mul_a = hd_ff;
            mul_b = od_ff;
         end
      endcase
   end

   assign prod     = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   assign prod_ovf = (prod[PROD_BITS-1:STATE_BITS-1] !=
                      {(PROD_BITS-STATE_BITS+1){prod[STATE_BITS-1]}});

   assign sum     = {pn_ff[STATE_BITS-1], pn_ff} + {px_ff[STATE_BITS-1], px_ff};
   assign sum_ovf = sum[STATE_BITS] ^ sum[STATE_BITS-1];

   // form the candidate fraction and status
   always_comb begin
      cand_n_in = hn_ff;
      cand_d_in = hd_ff;
      status_in = STATUS_OK;
      commit_in = 1'b0;
      unique case (op_ff)
         OP_LOAD: begin
            cand_n_in = on_ext;
            cand_d_in = od_ext;
            commit_in = 1'b1;
         end
         OP_ADD: begin
            if (hd_ff == '0 || od_ff == '0) begin
               status_in = STATUS_ZERO_DEN;
            end else if (ovf_ff || sum_ovf) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               cand_n_in = sum[STATE_BITS-1:0];
               cand_d_in = pd_ff;
               commit_in = 1'b1;
            end
         end
         OP_MUL: begin
            if (ovf_ff) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               cand_n_in = pn_ff;
               cand_d_in = pd_ff;
               commit_in = 1'b1;
            end
         end
         default: begin
            commit_in = 1'b0;
         end
      endcase
      reduce_in = commit_in && (op_ff != OP_LOAD) &&
                  !cand_n_in[STATE_BITS-1] && (cand_n_in != '0) &&
                  !cand_d_in[STATE_BITS-1] && (cand_d_in != '0);
   end

   assign gcd_eq = (ga_ff == gb_ff);
   assign rn_sh  = {rn_ff[STATE_BITS-2:0], qn_ff[STATE_BITS-1]};
   assign rd_sh  = {rd_ff[STATE_BITS-2:0], qd_ff[STATE_BITS-1]};

   always_comb begin
      hn_in  = hn_ff;
      hd_in  = hd_ff;
      ovf_in = ovf_ff;
      ga_in  = ga_ff;
      gb_in  = gb_ff;
      gk_in  = gk_ff;
      g_in   = g_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      out_n_in = out_n_ff;
      out_d_in = out_d_ff;
      out_s_in = out_s_ff;

      if (cmd.accept) begin
         ovf_in = 1'b0;
      end else if (cmd.mul_en) begin
         ovf_in = ovf_ff | prod_ovf;
      end

      if (cmd.form) begin
         ga_in = cand_n_in;
         gb_in = cand_d_in;
         gk_in = '0;
      end

      // binary gcd: strip common twos, then subtract odd from odd
      if (cmd.gcd_step) begin
         if (gcd_eq) begin
            g_in   = ga_ff << gk_ff;
            qn_in  = cand_n_ff;
            qd_in  = cand_d_ff;
            rn_in  = '0;
            rd_in  = '0;
            cnt_in = '0;
         end else if (!ga_ff[0] && !gb_ff[0]) begin
            ga_in = ga_ff >> 1;
            gb_in = gb_ff >> 1;
            gk_in = gk_ff + CNT_BITS'(1);
         end else if (!ga_ff[0]) begin
            ga_in = ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_in = gb_ff >> 1;
         end else if (ga_ff > gb_ff) begin
            ga_in = (ga_ff - gb_ff) >> 1;
         end else begin
            gb_in = (gb_ff - ga_ff) >> 1;
         end
      end

      // restoring division of both parts, one quotient bit per cycle
      if (cmd.div_step) begin
         if (rn_sh >= g_ff) begin
            rn_in = rn_sh - g_ff;
            qn_in = {qn_ff[STATE_BITS-2:0], 1'b1};
         end else begin
            rn_in = rn_sh;
            qn_in = {qn_ff[STATE_BITS-2:0], 1'b0};
         end
         if (rd_sh >= g_ff) begin
            rd_in = rd_sh - g_ff;
            qd_in = {qd_ff[STATE_BITS-2:0], 1'b1};
         end else begin
            rd_in = rd_sh;
            qd_in = {qd_ff[STATE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      if (cmd.out_load) begin
         if (commit_ff) begin
            hn_in = cand_n_ff;
            hd_in = cand_d_ff;
         end
         out_n_in = commit_ff ? cand_n_ff : hn_ff;
         out_d_in = commit_ff ? cand_d_ff : hd_ff;
         out_s_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hn_ff <= '0;
         hd_ff <= STATE_BITS'(1);
      end else begin
         hn_ff <= hn_in;
         hd_ff <= hd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_operation;
         on_ff <= req_operand_numerator;
         od_ff <= req_operand_denominator;
      end
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            MUL_DEN:   pd_ff <= prod[STATE_BITS-1:0];
            MUL_NUM:   pn_ff <= prod[STATE_BITS-1:0];
            MUL_CROSS: px_ff <= prod[STATE_BITS-1:0];
            default:   pd_ff <= prod[STATE_BITS-1:0];
         endcase
      end
      if (cmd.form) begin
         cand_n_ff <= cand_n_in;
         cand_d_ff <= cand_d_in;
         status_ff <= status_in;
         commit_ff <= commit_in;
      end else if (cmd.div_step && cnt_ff == DIV_LAST) begin
         cand_n_ff <= qn_in;
         cand_d_ff <= qd_in;
      end
      ovf_ff   <= ovf_in;
      ga_ff    <= ga_in;
      gb_ff    <= gb_in;
      gk_ff    <= gk_in;
      g_ff     <= g_in;
      qn_ff    <= qn_in;
      qd_ff    <= qd_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      cnt_ff   <= cnt_in;
      out_n_ff <= out_n_in;
      out_d_ff <= out_d_in;
      out_s_ff <= out_s_in;
   end

   assign stat.op         = op_ff;
   assign stat.reduce_req = reduce_in;
   assign stat.gcd_equal  = gcd_eq;
   assign stat.div_last   = (cnt_ff == DIV_LAST);

   assign rsp_result_numerator   = out_n_ff;
   assign rsp_result_denominator = out_d_ff;
   assign rsp_status             = out_s_ff;

   `RAR_ASSERT_NEXT(a_error_keeps_state, cmd.out_load && status_ff != STATUS_OK, $stable(hn_ff) && $stable(hd_ff), "held fraction changed on an error item")
   `RAR_ASSERT_IMPL(a_gcd_pair_nonzero, cmd.gcd_step, ga_ff != '0 && gb_ff != '0, "gcd unit reached a zero operand")
   `RAR_ASSERT_IMPL(a_divisor_nonzero, cmd.div_step, g_ff != '0, "divider started with a zero divisor")

endmodule

`default_nettype wire
